// ===== rtl/dnsa_pkg.sv =====
// Shared types and constants for the DNS response A-record extractor.
package dnsa_pkg;

    localparam logic [15:0] FLAG_MASK = 16'hfb7f;
    localparam logic [15:0] FLAG_WANT = 16'h8100;
    localparam logic [15:0] TYPE_A    = 16'h0001;

    localparam logic [3:0] HDR_LAST_POS    = 4'd11;
    localparam logic [3:0] QFIXED_LAST_POS = 4'd3;
    localparam logic [3:0] AFIXED_LAST_POS = 4'd9;
    localparam logic [3:0] ADDR_BYTES      = 4'd4;

    typedef enum logic [3:0] {
        PH_HEADER = 4'd0,
        PH_QNAME  = 4'd1,
        PH_QFIXED = 4'd2,
        PH_ANAME  = 4'd3,
        PH_APTR   = 4'd4,
        PH_AFIXED = 4'd5,
        PH_RDATA  = 4'd6,
        PH_DONE   = 4'd7
    } phase_t;

    typedef enum logic [1:0] {
        OC_PENDING   = 2'd0,
        OC_ACCEPT    = 2'd1,
        OC_REJECT    = 2'd2,
        OC_MALFORMED = 2'd3
    } outcome_t;

    typedef enum logic [2:0] {
        KIND_ADDRESS   = 3'd0,
        KIND_ACCEPTED  = 3'd1,
        KIND_REJECTED  = 3'd2,
        KIND_MALFORMED = 3'd3,
        KIND_TRUNCATED = 3'd4
    } kind_t;

    typedef struct packed {
        logic        has_addr;
        logic [31:0] addr;
        logic        has_status;
        kind_t       status;
    } event_t;

endpackage

// ===== rtl/dnsa_ifs.sv =====
// Valid/ready channel interfaces for datagram bytes and extracted results.
interface dnsa_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_datagram;

    modport source (output valid, output data_byte, output end_of_datagram, input ready);
    modport sink (input valid, input data_byte, input end_of_datagram, output ready);
endinterface

interface dnsa_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] address;
    logic        last;

    modport source (output valid, output kind, output address, output last, input ready);
    modport sink (input valid, input kind, input address, input last, output ready);
endinterface

// ===== rtl/dns_response_a_record_extractor.sv =====
// Top level of the DNS response A-record extractor.
//
//   channel   dir   beat contents
//   in_ch     in    data_byte[7:0], end_of_datagram
//   out_ch    out   kind[2:0], address[31:0], last
//   cfg       in    cfg_wr_en, cfg_wr_data[15:0] (expected_id)
//
// One byte per cycle; the parser state machine updates in the accepting cycle.
// A byte yields up to two beats; the emitter drains one beat per cycle, so a
// full event queue of QUEUE_DEPTH entries holds off in_ch.ready.
// Reset clears parser state, queue and output register; expected_id resets to zero.
// A stalled out_ch backs up into the queue and then into in_ch.
module dns_response_a_record_extractor #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    dnsa_byte_if.sink            in_ch,
    dnsa_result_if.source        out_ch,
    input  logic                 cfg_wr_en,
    input  logic [15:0]          cfg_wr_data
);

    logic [15:0]      expected_id_reg;
    logic             q_full;
    logic             q_empty;
    logic             q_push;
    logic             q_pop;
    dnsa_pkg::event_t push_event;
    dnsa_pkg::event_t head_event;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_id_reg <= 16'd0;
        else if (cfg_wr_en)
            expected_id_reg <= cfg_wr_data;
    end

    dnsa_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_ch.valid),
        .in_ready        (in_ch.ready),
        .data_byte       (in_ch.data_byte),
        .end_of_datagram (in_ch.end_of_datagram),
        .expected_id     (expected_id_reg),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_event         (push_event)
    );

    dnsa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_event (push_event),
        .pop        (q_pop),
        .head_event (head_event),
        .full       (q_full),
        .empty      (q_empty)
    );

    dnsa_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_event  (head_event),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_ch.valid),
        .out_ready   (out_ch.ready),
        .out_kind    (out_ch.kind),
        .out_address (out_ch.address),
        .out_last    (out_ch.last)
    );

endmodule

// ===== rtl/dnsa_front.sv =====
// Byte parser: walks header, questions and answers and posts result events.
module dnsa_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              end_of_datagram,
    input  logic [15:0]       expected_id,
    input  logic              q_full,
    output logic              q_push,
    output dnsa_pkg::event_t  q_event
);

    dnsa_pkg::phase_t   phase_reg, phase_next;
    dnsa_pkg::outcome_t outcome_reg, outcome_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] hword_reg, hword_next;
    logic [15:0] qleft_reg, qleft_next;
    logic [15:0] aleft_reg, aleft_next;
    logic [5:0]  label_reg, label_next;
    logic [15:0] rtype_reg, rtype_next;
    logic [15:0] rleft_reg, rleft_next;
    logic [31:0] acc_reg, acc_next;

    logic        accept;
    logic        emit_addr;
    logic [15:0] shift_word;
    logic [15:0] qdec;
    logic [15:0] adec;
    logic [15:0] rdec;
    logic [31:0] acc_shift;
    logic        in_answer;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign shift_word = {hword_reg[7:0], data_byte};
    assign qdec       = qleft_reg - 16'd1;
    assign adec       = aleft_reg - 16'd1;
    assign rdec       = rleft_reg - 16'd1;
    assign acc_shift  = {acc_reg[23:0], data_byte};
    assign in_answer  = (phase_reg == dnsa_pkg::PH_ANAME);

    always_comb
    begin
        phase_next   = phase_reg;
        outcome_next = outcome_reg;
        pos_next     = pos_reg;
        hword_next   = hword_reg;
        qleft_next   = qleft_reg;
        aleft_next   = aleft_reg;
        label_next   = label_reg;
        rtype_next   = rtype_reg;
        rleft_next   = rleft_reg;
        acc_next     = acc_reg;
        emit_addr    = 1'b0;

        unique case (phase_reg)
            dnsa_pkg::PH_HEADER:
            begin
                hword_next = shift_word;
                if (pos_reg == 4'd1 && shift_word != expected_id)
                begin
                    phase_next   = dnsa_pkg::PH_DONE;
                    outcome_next = dnsa_pkg::OC_REJECT;
                end
                else if (pos_reg == 4'd3
                         && (shift_word & dnsa_pkg::FLAG_MASK) != dnsa_pkg::FLAG_WANT)
                begin
                    phase_next   = dnsa_pkg::PH_DONE;
                    outcome_next = dnsa_pkg::OC_REJECT;
                end
                else if (pos_reg == 4'd7 && shift_word == 16'd0)
                begin
                    aleft_next   = shift_word;
                    phase_next   = dnsa_pkg::PH_DONE;
                    outcome_next = dnsa_pkg::OC_REJECT;
                end
                else
                begin
                    if (pos_reg == 4'd5)
                        qleft_next = shift_word;
                    if (pos_reg == 4'd7)
                        aleft_next = shift_word;
                    if (pos_reg >= dnsa_pkg::HDR_LAST_POS)
                    begin
                        phase_next = (qleft_reg != 16'd0) ? dnsa_pkg::PH_QNAME
                                                          : dnsa_pkg::PH_ANAME;
                        label_next = 6'd0;
                        pos_next   = 4'd0;
                    end
                    else
                        pos_next = pos_reg + 4'd1;
                end
            end
            dnsa_pkg::PH_QNAME, dnsa_pkg::PH_ANAME:
            begin
                if (label_reg != 6'd0)
                    label_next = label_reg - 6'd1;
                else if (data_byte == 8'd0)
                begin
                    phase_next = in_answer ? dnsa_pkg::PH_AFIXED : dnsa_pkg::PH_QFIXED;
                    pos_next   = 4'd0;
                    hword_next = 16'd0;
                end
                else if (data_byte[7:6] == 2'b00)
                    label_next = data_byte[5:0];
                else if (data_byte[7:6] == 2'b11 && in_answer)
                    phase_next = dnsa_pkg::PH_APTR;
                else
                begin
                    phase_next   = dnsa_pkg::PH_DONE;
                    outcome_next = dnsa_pkg::OC_MALFORMED;
                end
            end
            dnsa_pkg::PH_QFIXED:
            begin
                if (pos_reg >= dnsa_pkg::QFIXED_LAST_POS)
                begin
                    qleft_next = qdec;
                    phase_next = (qdec != 16'd0) ? dnsa_pkg::PH_QNAME : dnsa_pkg::PH_ANAME;
                    label_next = 6'd0;
                    pos_next   = 4'd0;
                end
                else
                    pos_next = pos_reg + 4'd1;
            end
            dnsa_pkg::PH_APTR:
            begin
                phase_next = dnsa_pkg::PH_AFIXED;
                pos_next   = 4'd0;
                hword_next = 16'd0;
            end
            dnsa_pkg::PH_AFIXED:
            begin
                hword_next = shift_word;
                if (pos_reg == 4'd1)
                    rtype_next = shift_word;
                if (pos_reg >= dnsa_pkg::AFIXED_LAST_POS)
                begin
                    rleft_next = shift_word;
                    pos_next   = 4'd0;
                    acc_next   = 32'd0;
                    if (rtype_reg == dnsa_pkg::TYPE_A && shift_word < 16'd4)
                    begin
                        phase_next   = dnsa_pkg::PH_DONE;
                        outcome_next = dnsa_pkg::OC_MALFORMED;
                    end
                    else if (shift_word == 16'd0)
                    begin
                        aleft_next = adec;
                        if (adec == 16'd0)
                        begin
                            phase_next   = dnsa_pkg::PH_DONE;
                            outcome_next = dnsa_pkg::OC_ACCEPT;
                        end
                        else
                        begin
                            phase_next = dnsa_pkg::PH_ANAME;
                            label_next = 6'd0;
                        end
                    end
                    else
                        phase_next = dnsa_pkg::PH_RDATA;
                end
                else
                    pos_next = pos_reg + 4'd1;
            end
            dnsa_pkg::PH_RDATA:
            begin
                if (rtype_reg == dnsa_pkg::TYPE_A && pos_reg < dnsa_pkg::ADDR_BYTES)
                begin
                    acc_next  = acc_shift;
                    pos_next  = pos_reg + 4'd1;
                    emit_addr = (pos_reg == dnsa_pkg::ADDR_BYTES - 4'd1);
                end
                rleft_next = rdec;
                if (rdec == 16'd0)
                begin
                    aleft_next = adec;
                    if (adec == 16'd0)
                    begin
                        phase_next   = dnsa_pkg::PH_DONE;
                        outcome_next = dnsa_pkg::OC_ACCEPT;
                    end
                    else
                    begin
                        phase_next = dnsa_pkg::PH_ANAME;
                        label_next = 6'd0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        q_event.has_addr   = emit_addr;
        q_event.addr       = acc_shift;
        q_event.has_status = end_of_datagram;
        unique case (outcome_next)
            dnsa_pkg::OC_ACCEPT:    q_event.status = dnsa_pkg::KIND_ACCEPTED;
            dnsa_pkg::OC_REJECT:    q_event.status = dnsa_pkg::KIND_REJECTED;
            dnsa_pkg::OC_MALFORMED: q_event.status = dnsa_pkg::KIND_MALFORMED;
            default:                q_event.status = dnsa_pkg::KIND_TRUNCATED;
        endcase
        q_push = accept && (emit_addr || end_of_datagram);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= dnsa_pkg::PH_HEADER;
            outcome_reg <= dnsa_pkg::OC_PENDING;
            pos_reg     <= 4'd0;
            hword_reg   <= 16'd0;
            qleft_reg   <= 16'd0;
            aleft_reg   <= 16'd0;
            label_reg   <= 6'd0;
            rtype_reg   <= 16'd0;
            rleft_reg   <= 16'd0;
            acc_reg     <= 32'd0;
        end
        else if (accept)
        begin
            if (end_of_datagram)
            begin
                phase_reg   <= dnsa_pkg::PH_HEADER;
                outcome_reg <= dnsa_pkg::OC_PENDING;
                pos_reg     <= 4'd0;
                hword_reg   <= 16'd0;
                qleft_reg   <= 16'd0;
                aleft_reg   <= 16'd0;
                label_reg   <= 6'd0;
                rtype_reg   <= 16'd0;
                rleft_reg   <= 16'd0;
                acc_reg     <= 32'd0;
            end
            else
            begin
                phase_reg   <= phase_next;
                outcome_reg <= outcome_next;
                pos_reg     <= pos_next;
                hword_reg   <= hword_next;
                qleft_reg   <= qleft_next;
                aleft_reg   <= aleft_next;
                label_reg   <= label_next;
                rtype_reg   <= rtype_next;
                rleft_reg   <= rleft_next;
                acc_reg     <= acc_next;
            end
        end
    end

endmodule

// ===== rtl/dnsa_queue.sv =====
// Small event queue between the parser and the result emitter.
module dnsa_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dnsa_pkg::event_t  push_event,
    input  logic              pop,
    output dnsa_pkg::event_t  head_event,
    output logic              full,
    output logic              empty
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    dnsa_pkg::event_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push;
    logic          do_pop;

    assign full       = (count_reg == DEPTH_CNT);
    assign empty      = (count_reg == '0);
    assign do_push    = push && !full;
    assign do_pop     = pop && !empty;
    assign head_event = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_event;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/dnsa_back.sv =====
// Result emitter: splits queued events into address and status beats.
module dnsa_back (
    input  logic              clk,
    input  logic              rst_n,
    input  dnsa_pkg::event_t  head_event,
    input  logic              q_empty,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        out_kind,
    output logic [31:0]       out_address,
    output logic              out_last
);

    logic            valid_reg, valid_next;
    logic [2:0]      kind_reg, kind_next;
    logic [31:0]     addr_reg, addr_next;
    logic            last_reg, last_next;
    logic            pend_reg, pend_next;
    dnsa_pkg::kind_t pend_kind_reg, pend_kind_next;
    logic            load;

    assign load        = !valid_reg || out_ready;
    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_address = addr_reg;
    assign out_last    = last_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        last_next      = last_reg;
        pend_next      = pend_reg;
        pend_kind_next = pend_kind_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            priority if (pend_reg)
            begin
                valid_next = 1'b1;
                kind_next  = pend_kind_reg;
                addr_next  = 32'd0;
                last_next  = 1'b1;
                pend_next  = 1'b0;
            end
            else if (!q_empty)
            begin
                q_pop      = 1'b1;
                valid_next = 1'b1;
                if (head_event.has_addr)
                begin
                    kind_next      = dnsa_pkg::KIND_ADDRESS;
                    addr_next      = head_event.addr;
                    last_next      = 1'b0;
                    pend_next      = head_event.has_status;
                    pend_kind_next = head_event.status;
                end
                else
                begin
                    kind_next = head_event.status;
                    addr_next = 32'd0;
                    last_next = 1'b1;
                end
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        addr_reg      <= addr_next;
        last_reg      <= last_next;
        pend_kind_reg <= pend_kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

endmodule
